// ===== sv/rtt_pkg.sv =====
`default_nettype none

package rtt_pkg;

  localparam int BOUND_W    = 33;
  localparam int KEY_W      = 32;
  localparam int KW_W       = 6;
  localparam int SPAN_W     = KEY_W + 1;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_PREP,
    ST_RUN,
    ST_SEG2,
    ST_EMPTY
  } rtt_state_t;

  typedef struct packed {
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;
    logic [KEY_W-1:0]   key_mask;
    logic               sgn;
    logic               empty;
  } rtt_clamp_t;

  typedef struct packed {
    logic [SPAN_W-1:0] cur_next;
    logic [SPAN_W-1:0] rem_next;
    logic [KEY_W-1:0]  entry_mask;
  } rtt_step_t;

  function automatic logic [SPAN_W-1:0] bit_rev(input logic [SPAN_W-1:0] x);
    logic [SPAN_W-1:0] r;
    for (int i = 0; i < SPAN_W; i++) begin
      r[i] = x[SPAN_W-1-i];
    end
    return r;
  endfunction

  function automatic logic [SPAN_W-1:0] lowest_one(input logic [SPAN_W-1:0] x);
    return x & (~x + {{(SPAN_W-1){1'b0}}, 1'b1});
  endfunction

endpackage

`default_nettype wire

// ===== sv/rtt_clamp.sv =====
`default_nettype none

module rtt_clamp #(
  parameter int MAX_KEY_WIDTH = 32
) (
  input  wire logic [rtt_pkg::BOUND_W-1:0] range_low,
  input  wire logic [rtt_pkg::BOUND_W-1:0] range_high,
  input  wire logic                        is_signed,
  input  wire logic [rtt_pkg::KW_W-1:0]    key_width,
  output rtt_pkg::rtt_clamp_t              clamp
);

  localparam logic [rtt_pkg::KW_W-1:0] MAX_W = rtt_pkg::KW_W'(MAX_KEY_WIDTH);
  localparam logic [rtt_pkg::KW_W-1:0] ONE_W = rtt_pkg::KW_W'(1);

  logic [rtt_pkg::KW_W-1:0]      w;
  logic [rtt_pkg::BOUND_W-1:0]   ones;
  logic [rtt_pkg::BOUND_W-1:0]   span_mask;
  logic [rtt_pkg::BOUND_W-1:0]   half_mask;
  logic signed [rtt_pkg::BOUND_W:0] kmin;
  logic signed [rtt_pkg::BOUND_W:0] kmax;
  logic signed [rtt_pkg::BOUND_W:0] lo_ext;
  logic signed [rtt_pkg::BOUND_W:0] hi_ext;
  logic signed [rtt_pkg::BOUND_W:0] lo_sat;
  logic signed [rtt_pkg::BOUND_W:0] hi_sat;

  always_comb begin
    if (key_width == '0) begin
      w = ONE_W;
    end else if (key_width > MAX_W) begin
      w = MAX_W;
    end else begin
      w = key_width;
    end
  end

  assign ones      = '1;
  assign span_mask = ~(ones << w);
  assign half_mask = ~(ones << (w - ONE_W));

  assign kmax = is_signed ? $signed({1'b0, half_mask}) : $signed({1'b0, span_mask});
  assign kmin = is_signed ? $signed(~{1'b0, half_mask}) : '0;

  assign lo_ext = $signed({range_low[rtt_pkg::BOUND_W-1], range_low});
  assign hi_ext = $signed({range_high[rtt_pkg::BOUND_W-1], range_high});

  always_comb begin
    if (lo_ext < kmin) begin
      lo_sat = kmin;
    end else if (lo_ext > kmax) begin
      lo_sat = kmax;
    end else begin
      lo_sat = lo_ext;
    end
    if (hi_ext < kmin) begin
      hi_sat = kmin;
    end else if (hi_ext > kmax) begin
      hi_sat = kmax;
    end else begin
      hi_sat = hi_ext;
    end
  end

  assign clamp.lo        = lo_sat[rtt_pkg::BOUND_W-1:0];
  assign clamp.hi        = hi_sat[rtt_pkg::BOUND_W-1:0];
  assign clamp.key_mask  = span_mask[rtt_pkg::KEY_W-1:0];
  assign clamp.sgn       = is_signed;
  assign clamp.empty     = hi_ext < lo_ext;

endmodule

`default_nettype wire

// ===== sv/rtt_step.sv =====
`default_nettype none

module rtt_step (
  input  wire logic [rtt_pkg::SPAN_W-1:0] cur,
  input  wire logic [rtt_pkg::SPAN_W-1:0] rem,
  input  wire logic [rtt_pkg::KEY_W-1:0]  key_mask,
  output rtt_pkg::rtt_step_t              step
);

  localparam logic [rtt_pkg::SPAN_W-1:0] ONE = rtt_pkg::SPAN_W'(1);

  logic [rtt_pkg::SPAN_W-1:0] neg_cur;
  logic [rtt_pkg::SPAN_W-1:0] align_bit;
  logic [rtt_pkg::SPAN_W-1:0] top_bit;
  logic [rtt_pkg::SPAN_W-1:0] stride;
  logic [rtt_pkg::SPAN_W-1:0] upper;
  logic                       fits;

  // The aligned block at cur is used when it fits in what is left;
  // otherwise the largest power of two within the remaining count is.
  assign neg_cur   = ~cur + ONE;
  assign align_bit = cur & neg_cur;
  assign fits      = |(rem & (cur | neg_cur));
  assign top_bit   = rtt_pkg::bit_rev(rtt_pkg::lowest_one(rtt_pkg::bit_rev(rem)));
  assign stride    = fits ? align_bit : top_bit;
  assign upper     = stride | (~stride + ONE);

  assign step.cur_next   = cur + stride;
  assign step.rem_next   = rem - stride;
  assign step.entry_mask = upper[rtt_pkg::KEY_W-1:0] & key_mask;

endmodule

`default_nettype wire

// ===== sv/range_to_ternary_masks_top.sv =====
`default_nettype none

// Covers one inclusive integer range with ternary value/mask entries, each the
// largest aligned power-of-two block that starts at the current value and fits.
// A request is taken only when the block is idle and is latched at acceptance.
// Bound saturation (CLAMP) and span preparation (PREP) then follow in turn; after
// that the single step unit produces one entry per cycle while the output
// accepts, up to 2*w entries for key width w (at most 64), with the SEG2 state
// between the two parts of a signed range that crosses zero. An inverted range
// yields one flagged entry from the EMPTY state that follows saturation. Output
// stalls hold the step unit, and each entry is registered and appears in the
// cycle after it is computed.
module range_to_ternary_masks_top #(
  parameter int MAX_KEY_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // range_low[32:0], range_high[65:33], key_width[71:66]
  input  wire logic [rtt_pkg::IN_DATA_W-1:0]  s_tdata,
  // is_signed[0]
  input  wire logic [0:0]                     s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // match_value[31:0], match_mask[63:32]
  output logic [rtt_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                m_tlast,
  // empty_range[0]
  output logic [0:0]                          m_tuser
);

  localparam int KW_LO = 2 * rtt_pkg::BOUND_W;
  localparam logic [rtt_pkg::SPAN_W-1:0] ONE = rtt_pkg::SPAN_W'(1);

  rtt_pkg::rtt_state_t state;
  rtt_pkg::rtt_state_t state_next;

  logic [rtt_pkg::BOUND_W-1:0] in_low;
  logic [rtt_pkg::BOUND_W-1:0] in_high;
  logic                        in_sgn;
  logic [rtt_pkg::KW_W-1:0]    in_kw;

  rtt_pkg::rtt_clamp_t clamp_d;
  rtt_pkg::rtt_clamp_t clamp_q;
  rtt_pkg::rtt_step_t  step;

  logic [rtt_pkg::SPAN_W-1:0] cur;
  logic [rtt_pkg::SPAN_W-1:0] rem;
  logic                       second;

  logic [rtt_pkg::KEY_W-1:0]  lo_pat;
  logic [rtt_pkg::KEY_W-1:0]  hi_pat;
  logic [rtt_pkg::SPAN_W-1:0] prep_rem;
  logic [rtt_pkg::SPAN_W-1:0] seg2_rem;
  logic                       crossing;
  logic                       run_done;

  logic                       slot_free;
  logic                       emit_run;
  logic                       emit_empty;

  logic                       out_valid;
  logic [rtt_pkg::KEY_W-1:0]  out_value;
  logic [rtt_pkg::KEY_W-1:0]  out_mask;
  logic                       out_last;
  logic                       out_empty;

  rtt_clamp #(
    .MAX_KEY_WIDTH(MAX_KEY_WIDTH)
  ) u_clamp (
    .range_low (in_low),
    .range_high(in_high),
    .is_signed (in_sgn),
    .key_width (in_kw),
    .clamp     (clamp_d)
  );

  rtt_step u_step (
    .cur     (cur),
    .rem     (rem),
    .key_mask(clamp_q.key_mask),
    .step    (step)
  );

  assign lo_pat   = clamp_q.lo[rtt_pkg::KEY_W-1:0] & clamp_q.key_mask;
  assign crossing = clamp_q.sgn && clamp_q.lo[rtt_pkg::BOUND_W-1]
                    && !clamp_q.hi[rtt_pkg::BOUND_W-1];
  assign hi_pat   = crossing ? clamp_q.key_mask
                             : (clamp_q.hi[rtt_pkg::KEY_W-1:0] & clamp_q.key_mask);
  assign prep_rem = {1'b0, hi_pat} - {1'b0, lo_pat} + ONE;
  assign seg2_rem = {1'b0, clamp_q.hi[rtt_pkg::KEY_W-1:0]} + ONE;
  assign run_done = step.rem_next == '0;

  always_comb begin
    state_next = state;
    unique case (state)
      rtt_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = rtt_pkg::ST_CLAMP;
        end
      end
      rtt_pkg::ST_CLAMP: begin
        state_next = clamp_d.empty ? rtt_pkg::ST_EMPTY : rtt_pkg::ST_PREP;
      end
      rtt_pkg::ST_PREP: begin
        state_next = rtt_pkg::ST_RUN;
      end
      rtt_pkg::ST_RUN: begin
        if (slot_free && run_done) begin
          state_next = second ? rtt_pkg::ST_SEG2 : rtt_pkg::ST_IDLE;
        end
      end
      rtt_pkg::ST_SEG2: begin
        state_next = rtt_pkg::ST_RUN;
      end
      rtt_pkg::ST_EMPTY: begin
        if (slot_free) begin
          state_next = rtt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rtt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready   = state == rtt_pkg::ST_IDLE;
    slot_free  = !out_valid || m_tready;
    emit_run   = (state == rtt_pkg::ST_RUN) && slot_free;
    emit_empty = (state == rtt_pkg::ST_EMPTY) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_low  <= s_tdata[rtt_pkg::BOUND_W-1:0];
      in_high <= s_tdata[KW_LO-1:rtt_pkg::BOUND_W];
      in_kw   <= s_tdata[KW_LO+rtt_pkg::KW_W-1:KW_LO];
      in_sgn  <= s_tuser[0];
    end
    if (state == rtt_pkg::ST_CLAMP) begin
      clamp_q <= clamp_d;
    end
    if (state == rtt_pkg::ST_PREP) begin
      cur    <= {1'b0, lo_pat};
      rem    <= prep_rem;
      second <= crossing;
    end else if (state == rtt_pkg::ST_SEG2) begin
      cur    <= '0;
      rem    <= seg2_rem;
      second <= 1'b0;
    end else if (emit_run) begin
      cur <= step.cur_next;
      rem <= step.rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_run || emit_empty) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_run) begin
      out_value <= cur[rtt_pkg::KEY_W-1:0];
      out_mask  <= step.entry_mask;
      out_last  <= run_done && !second;
      out_empty <= 1'b0;
    end else if (emit_empty) begin
      out_value <= '0;
      out_mask  <= '0;
      out_last  <= 1'b1;
      out_empty <= 1'b1;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = {out_mask, out_value};
  assign m_tlast    = out_last;
  assign m_tuser[0] = out_empty;

endmodule

`default_nettype wire
